@@ rtl/glyph_blit_address_generator_core_macros.svh @@
// Assertion macros for the glyph blit address generator.
// Included by the RTL modules that carry concurrent checks; needs no other file.
`ifndef GLYPH_BLIT_ADDRESS_GENERATOR_CORE_MACROS_SVH
`define GLYPH_BLIT_ADDRESS_GENERATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Plain property check, disabled while reset is asserted.
`define GBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("glyph blit assertion failed");
// Antecedent in one cycle implies consequent in the next.
`define GBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("glyph blit assertion failed");
`else
`define GBA_ASSERT(lbl, clk, rstn, prop)
`define GBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/gba_pkg.sv @@
// Shared types and constants of the glyph blit address generator.
// No dependencies; used by every module of the block.
`default_nettype none

package gba_pkg;

  // First and last drawable character codes.
  localparam logic [7:0] FIRST_CODE = 8'd33;
  localparam logic [7:0] LAST_CODE  = 8'd127;

  // Width of the atlas cell index (code - 33) * glyph size, at most 94 * 64.
  localparam int unsigned N_W = 13;

  // Configuration register indexes.
  localparam logic [2:0] REG_GLYPH_SIZE  = 3'd0;
  localparam logic [2:0] REG_SPACING     = 3'd1;
  localparam logic [2:0] REG_OFFSET_Y    = 3'd2;
  localparam logic [2:0] REG_OFFSET_X    = 3'd3;
  localparam logic [2:0] REG_ATLAS_WIDTH = 3'd4;
  localparam logic [2:0] REG_DEST_WIDTH  = 3'd5;
  localparam logic [2:0] REG_DEST_HEIGHT = 3'd6;

  typedef struct packed {
    logic [6:0]  glyph_size;
    logic [7:0]  spacing;
    logic [11:0] offset_y;
    logic [11:0] offset_x;
    logic [12:0] atlas_width;
    logic [15:0] dest_width;
    logic [15:0] dest_height;
  } gba_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_LOAD,
    ST_EMIT
  } gba_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic calc;
    logic div_step;
    logic mul1;
    logic mul2;
    logic load;
    logic advance;
  } gba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;
    logic last;
  } gba_sts_t;

endpackage

`default_nettype wire

@@ rtl/gba_cfg_regs.sv @@
// Configuration register file of the glyph blit address generator.
// Depends on gba_pkg for the register indexes and the configuration struct.
`default_nettype none

module gba_cfg_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [15:0]      cfg_data_i,
  output gba_pkg::gba_cfg_t     cfg_o
);

  gba_pkg::gba_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gba_pkg::REG_GLYPH_SIZE:  cfg_d.glyph_size  = cfg_data_i[6:0];
        gba_pkg::REG_SPACING:     cfg_d.spacing     = cfg_data_i[7:0];
        gba_pkg::REG_OFFSET_Y:    cfg_d.offset_y    = cfg_data_i[11:0];
        gba_pkg::REG_OFFSET_X:    cfg_d.offset_x    = cfg_data_i[11:0];
        gba_pkg::REG_ATLAS_WIDTH: cfg_d.atlas_width = cfg_data_i[12:0];
        gba_pkg::REG_DEST_WIDTH:  cfg_d.dest_width  = cfg_data_i[15:0];
        gba_pkg::REG_DEST_HEIGHT: cfg_d.dest_height = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_size  <= 7'd8;
      cfg_q.spacing     <= 8'd0;
      cfg_q.offset_y    <= 12'd0;
      cfg_q.offset_x    <= 12'd0;
      cfg_q.atlas_width <= 13'd1024;
      cfg_q.dest_width  <= 16'd1024;
      cfg_q.dest_height <= 16'd64;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/gba_datapath.sv @@
// Datapath of the glyph blit address generator: cell index, restoring divider,
// offset multipliers and the row offset accumulators. Depends on gba_pkg.
`default_nettype none

module gba_datapath #(
  parameter int unsigned BYTES_PER_PIXEL = 4,
  parameter int unsigned MAX_GLYPH       = 64
) (
  input  wire logic              clk_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic [11:0]       char_position_i,
  input  wire gba_pkg::gba_cfg_t cfg_i,
  input  wire gba_pkg::gba_cmd_t cmd_i,
  output gba_pkg::gba_sts_t      sts_o,
  output logic [31:0]            src_offset_o,
  output logic [31:0]            dest_offset_o,
  output logic                   last_row_o
);

  localparam int unsigned NW = gba_pkg::N_W;
  localparam logic [31:0] BPP = 32'(BYTES_PER_PIXEL);
  localparam logic [6:0]  GMAX = 7'(MAX_GLYPH);

  logic [7:0]    code_q;
  logic [11:0]   pos_q;
  logic [NW-1:0] quot_q;
  logic [NW-1:0] rem_q;
  logic [27:0]   oyd_q;
  logic [19:0]   prod1_q;
  logic [20:0]   pd_q;
  logic [31:0]   prod2_q;
  logic [31:0]   dsum_q;
  logic [31:0]   src_q;
  logic [31:0]   dest_q;
  logic [6:0]    rows_q;

  logic [6:0]    g;
  logic [7:0]    code_diff;
  logic [13:0]   n_full;
  logic [NW:0]   rem_sh;
  logic          q_bit;
  logic [8:0]    pitch;
  logic [32:0]   prod2_full;
  logic [31:0]   src_sum;
  logic [31:0]   src_step;
  logic [31:0]   dest_step;

  // Glyph sizes above the largest cell are clamped.
  assign g = (cfg_i.glyph_size > GMAX) ? GMAX : cfg_i.glyph_size;

  assign code_diff = code_q - gba_pkg::FIRST_CODE;
  assign n_full    = 14'(code_diff[6:0]) * 14'(g);

  // One quotient bit per cycle; rem_q stays below atlas_width.
  assign rem_sh = {rem_q, quot_q[NW-1]};
  assign q_bit  = (rem_sh >= {1'b0, cfg_i.atlas_width});

  assign pitch      = {2'b00, g} + {1'b0, cfg_i.spacing};
  assign prod2_full = 33'(prod1_q) * 33'(cfg_i.atlas_width);
  assign src_sum    = prod2_q + {{(32-NW){1'b0}}, rem_q};
  assign src_step   = {19'd0, cfg_i.atlas_width} * BPP;
  assign dest_step  = {16'd0, cfg_i.dest_width} * BPP;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      code_q <= char_code_i;
      pos_q  <= char_position_i;
    end
    if (cmd_i.calc) begin
      quot_q <= n_full[NW-1:0];
      rem_q  <= '0;
      oyd_q  <= 28'(cfg_i.offset_y) * 28'(cfg_i.dest_width);
    end
    if (cmd_i.div_step) begin
      quot_q <= {quot_q[NW-2:0], q_bit};
      rem_q  <= q_bit ? NW'(rem_sh - {1'b0, cfg_i.atlas_width}) : rem_sh[NW-1:0];
    end
    if (cmd_i.mul1) begin
      prod1_q <= 20'(quot_q) * 20'(g);
      pd_q    <= 21'(pos_q) * 21'(pitch);
    end
    if (cmd_i.mul2) begin
      prod2_q <= prod2_full[31:0];
      dsum_q  <= {4'd0, oyd_q} + {20'd0, cfg_i.offset_x} + {11'd0, pd_q};
    end
    if (cmd_i.load) begin
      src_q  <= src_sum * BPP;
      dest_q <= dsum_q * BPP;
      rows_q <= g;
    end else if (cmd_i.advance) begin
      src_q  <= src_q + src_step;
      dest_q <= dest_q + dest_step;
      rows_q <= rows_q - 7'd1;
    end
  end

  always_comb begin
    sts_o.skip = (cfg_i.offset_y > cfg_i.dest_height[11:0] && cfg_i.dest_height[15:12] == 4'd0)
              || ({4'd0, cfg_i.offset_x} > cfg_i.dest_width)
              || (code_q < gba_pkg::FIRST_CODE) || (code_q > gba_pkg::LAST_CODE)
              || (g == 7'd0) || (cfg_i.atlas_width == 13'd0);
    sts_o.last = (rows_q == 7'd1);
  end

  assign src_offset_o  = src_q;
  assign dest_offset_o = dest_q;
  assign last_row_o    = (rows_q == 7'd1);

endmodule

`default_nettype wire

@@ rtl/gba_ctrl.sv @@
// Controller state machine of the glyph blit address generator.
// Depends on gba_pkg and the assertion macro header.
`default_nettype none
`include "glyph_blit_address_generator_core_macros.svh"

module gba_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire gba_pkg::gba_sts_t sts_i,
  output gba_pkg::gba_cmd_t      cmd_o
);

  localparam int unsigned DIV_CNT_W = $clog2(gba_pkg::N_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(gba_pkg::N_W - 1);

  gba_pkg::gba_state_e state_q, state_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gba_pkg::ST_IDLE: if (in_valid_i) state_d = gba_pkg::ST_CALC;
      gba_pkg::ST_CALC: state_d = sts_i.skip ? gba_pkg::ST_IDLE : gba_pkg::ST_DIV;
      gba_pkg::ST_DIV:  if (div_cnt_q == DIV_LAST) state_d = gba_pkg::ST_MUL1;
      gba_pkg::ST_MUL1: state_d = gba_pkg::ST_MUL2;
      gba_pkg::ST_MUL2: state_d = gba_pkg::ST_LOAD;
      gba_pkg::ST_LOAD: state_d = gba_pkg::ST_EMIT;
      gba_pkg::ST_EMIT: if (out_ready_i && sts_i.last) state_d = gba_pkg::ST_IDLE;
      default:          state_d = gba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    div_cnt_d   = div_cnt_q;
    unique case (state_q)
      gba_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.latch_in  = in_valid_i;
      end
      gba_pkg::ST_CALC: begin
        cmd_o.calc = 1'b1;
        div_cnt_d  = '0;
      end
      gba_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + DIV_CNT_W'(1);
      end
      gba_pkg::ST_MUL1: cmd_o.mul1 = 1'b1;
      gba_pkg::ST_MUL2: cmd_o.mul2 = 1'b1;
      gba_pkg::ST_LOAD: cmd_o.load = 1'b1;
      gba_pkg::ST_EMIT: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gba_pkg::ST_IDLE;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  `GBA_ASSERT(a_div_cnt_range, clk_i, rst_ni, (state_q != gba_pkg::ST_DIV) || (div_cnt_q <= DIV_LAST))
  `GBA_ASSERT(a_no_overlap, clk_i, rst_ni, !(out_valid_o && in_ready_o))
  `GBA_ASSERT_NEXT(a_accept_to_calc, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == gba_pkg::ST_CALC)
  `GBA_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni, out_valid_o && out_ready_i && sts_i.last, state_q == gba_pkg::ST_IDLE)
  `GBA_ASSERT_NEXT(a_load_to_emit, clk_i, rst_ni, cmd_o.load, out_valid_o)

endmodule

`default_nettype wire

@@ rtl/glyph_blit_address_generator_core.sv @@
// A drawn character (code 33..127, origin not past the destination edges, nonzero glyph
// size and atlas width) is accepted, then the cell index is formed and bounds-checked, the
// bit-serial restoring divider splits the cell index by the atlas width, the offset
// multiplies and the load follow, and then one row beat per cycle is given while the
// output side is ready. A character that is not drawn gives no beat.
// The block works on one character at a time.
//
// Top level: configuration registers, controller and datapath.
// Depends on gba_pkg, gba_cfg_regs, gba_ctrl and gba_datapath.
`default_nettype none

module glyph_blit_address_generator_core #(
  parameter int unsigned BYTES_PER_PIXEL = 4,
  parameter int unsigned MAX_GLYPH       = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // Character input.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // char_code [7:0], char_position [19:8]
  // Row copy commands.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // src_offset [31:0], dest_offset [63:32]
  output logic             m_axis_tlast    // last_row
);

  gba_pkg::gba_cfg_t cfg;
  gba_pkg::gba_cmd_t cmd;
  gba_pkg::gba_sts_t sts;
  logic [31:0]       src_offset;
  logic [31:0]       dest_offset;

  gba_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gba_datapath #(
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL),
    .MAX_GLYPH       (MAX_GLYPH)
  ) u_dp (
    .clk_i           (clk_i),
    .char_code_i     (s_axis_tdata[7:0]),
    .char_position_i (s_axis_tdata[19:8]),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .src_offset_o    (src_offset),
    .dest_offset_o   (dest_offset),
    .last_row_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {dest_offset, src_offset};

endmodule

`default_nettype wire
